>>> hdl/sorted_open_list_queue_unit_assert.svh
// Assertion macros for the sorted open list queue.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef SORTED_OPEN_LIST_QUEUE_UNIT_ASSERT_SVH
`define SORTED_OPEN_LIST_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define SOLQ_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("solq assertion failed");

// Check a consequence in the cycle after a trigger.
`define SOLQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("solq assertion failed");

`else

`define SOLQ_ASSERT_ALWAYS(lbl, expr)
`define SOLQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/solq_pkg.sv
`default_nettype none

package solq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 64;
    localparam int STATE_CELLS = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_BITS    = STATE_CELLS * 4;

    // Bits of the state key that take part in a lookup
    localparam logic [63:0] KEY_MASK = (KEY_BITS >= 64) ? {64{1'b1}} :
                                       ((64'd1 << KEY_BITS) - 64'd1);

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_SCAN,
        S_INS_HEAD,
        S_POP_WAIT,
        S_LOOK_SCAN,
        S_FINISH
    } seq_state_t;

    // One stored entry: packed costs and state key
    typedef struct packed {
        logic [31:0] cost;
        logic [63:0] key;
    } entry_t;

endpackage

`default_nettype wire

>>> hdl/sorted_open_list_queue_unit.sv
// Sorted open list queue: a bounded priority queue for an A* search.
// Item channel: item_valid/item_stall carries op, total_cost, cost_so_far
// and state_key. Result channel: result_valid/result_stall carries status,
// found, the popped entry fields and entry_count; one result per item.
// Entries are held in one single-port-write, registered-read memory used as
// a ring; a head pointer makes pop a single read. Insert walks from the tail
// toward the head, moving larger entries back one slot per cycle. Lookup
// reads one entry per cycle until a match or the last entry is checked.
// One item is in work at a time: item_stall is high from acceptance until
// the sequencer returns to idle. The result sits in an output register, so
// the next item may be accepted while a result waits; a stalled result holds
// its fields, and the sequencer waits before finishing the following item.
// Reset empties the queue (count and head cleared); memory contents are not
// cleared and are never read before being written.
`default_nettype none

`include "sorted_open_list_queue_unit_assert.svh"

module sorted_open_list_queue_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire logic [1:0]                  op,
    input  wire logic [15:0]                 total_cost,
    input  wire logic [15:0]                 cost_so_far,
    input  wire logic [63:0]                 state_key,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic [1:0]                       status,
    output logic                             found,
    output logic [15:0]                      out_total_cost,
    output logic [15:0]                      out_cost_so_far,
    output logic [63:0]                      out_state_key,
    output logic [solq_pkg::COUNT_W-1:0]     entry_count
);

    localparam int AW = solq_pkg::ADDR_W;
    localparam int CW = solq_pkg::COUNT_W;

    // Map a ring position to a memory address
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                                input logic [AW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (AW+1)'(solq_pkg::QUEUE_DEPTH))
        begin
            sum = sum - (AW+1)'(solq_pkg::QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    solq_pkg::seq_state_t state_reg, state_next;

    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [1:0]      op_reg, op_next;
    logic [31:0]     cost_reg, cost_next;
    logic [63:0]     key_reg, key_next;

    // Result being built for the item in work
    logic [1:0]              res_status_reg, res_status_next;
    logic                    res_found_reg, res_found_next;
    solq_pkg::entry_t        res_entry_reg, res_entry_next;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              out_status_reg, out_status_next;
    logic                    out_found_reg, out_found_next;
    solq_pkg::entry_t        out_entry_reg, out_entry_next;
    logic [CW-1:0]           out_count_reg, out_count_next;

    // Entry memory
    solq_pkg::entry_t        mem [solq_pkg::QUEUE_DEPTH];
    solq_pkg::entry_t        rd_data_reg;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    solq_pkg::entry_t        wr_data;

    logic                    key_match;
    logic                    scan_last;

    assign key_match = ((rd_data_reg.key ^ key_reg) & solq_pkg::KEY_MASK) == 64'd0;
    assign scan_last = ({1'b0, idx_reg} + CW'(1)) == count_reg;

    assign item_stall      = (state_reg != solq_pkg::S_IDLE);
    assign result_valid    = out_valid_reg;
    assign status          = out_status_reg;
    assign found           = out_found_reg;
    assign out_total_cost  = out_entry_reg.cost[31:16];
    assign out_cost_so_far = out_entry_reg.cost[15:0];
    assign out_state_key   = out_entry_reg.key;
    assign entry_count     = out_count_reg;

    // Write and read the entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= solq_pkg::S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload state
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        cost_reg       <= cost_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_entry_reg  <= res_entry_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_entry_reg  <= out_entry_next;
        out_count_reg  <= out_count_next;
    end

    // Sequence one operation
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        cost_next       = cost_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_entry_next  = res_entry_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_entry_next  = out_entry_reg;
        out_count_next  = out_count_reg;
        rd_en           = 1'b0;
        rd_addr         = head_reg;
        wr_en           = 1'b0;
        wr_addr         = head_reg;
        wr_data         = '{cost: cost_reg, key: key_reg};

        // Drop the result once taken
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            solq_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next         = op;
                    cost_next       = {total_cost, cost_so_far};
                    key_next        = state_key;
                    res_status_next = solq_pkg::STATUS_OK;
                    res_found_next  = 1'b0;
                    res_entry_next  = '0;
                    state_next      = solq_pkg::S_DISPATCH;
                end
            end

            solq_pkg::S_DISPATCH:
            begin
                state_next = solq_pkg::S_FINISH;
                unique case (op_reg)
                    solq_pkg::OP_INSERT:
                    begin
                        if (count_reg == CW'(solq_pkg::QUEUE_DEPTH))
                        begin
                            res_status_next = solq_pkg::STATUS_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = head_reg;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            // Start at the tail entry
                            rd_en      = 1'b1;
                            idx_next   = AW'(count_reg - CW'(1));
                            rd_addr    = ring_addr(head_reg, idx_next);
                            state_next = solq_pkg::S_INS_SCAN;
                        end
                    end
                    solq_pkg::OP_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = solq_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = solq_pkg::S_POP_WAIT;
                        end
                    end
                    solq_pkg::OP_LOOKUP:
                    begin
                        if (count_reg != '0)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            idx_next   = '0;
                            state_next = solq_pkg::S_LOOK_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = solq_pkg::S_FINISH;
                    end
                endcase
            end

            solq_pkg::S_INS_SCAN:
            begin
                if (rd_data_reg.cost > cost_reg)
                begin
                    // Move the larger entry back one slot
                    wr_en   = 1'b1;
                    wr_addr = ring_addr(head_reg, idx_reg + AW'(1));
                    wr_data = rd_data_reg;
                    if (idx_reg == '0)
                    begin
                        state_next = solq_pkg::S_INS_HEAD;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        idx_next = idx_reg - AW'(1);
                        rd_addr  = ring_addr(head_reg, idx_next);
                    end
                end
                else
                begin
                    // Place the new entry behind this one
                    wr_en      = 1'b1;
                    wr_addr    = ring_addr(head_reg, idx_reg + AW'(1));
                    count_next = count_reg + CW'(1);
                    state_next = solq_pkg::S_FINISH;
                end
            end

            solq_pkg::S_INS_HEAD:
            begin
                wr_en      = 1'b1;
                wr_addr    = head_reg;
                count_next = count_reg + CW'(1);
                state_next = solq_pkg::S_FINISH;
            end

            solq_pkg::S_POP_WAIT:
            begin
                res_entry_next = rd_data_reg;
                count_next     = count_reg - CW'(1);
                head_next      = ring_addr(head_reg, AW'(1));
                state_next     = solq_pkg::S_FINISH;
            end

            solq_pkg::S_LOOK_SCAN:
            begin
                if (key_match)
                begin
                    res_found_next = 1'b1;
                    state_next     = solq_pkg::S_FINISH;
                end
                else if (scan_last)
                begin
                    state_next = solq_pkg::S_FINISH;
                end
                else
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + AW'(1);
                    rd_addr  = ring_addr(head_reg, idx_next);
                end
            end

            solq_pkg::S_FINISH:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_found_next  = res_found_reg;
                    out_entry_next  = res_entry_reg;
                    out_count_next  = count_reg;
                    state_next      = solq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = solq_pkg::S_IDLE;
            end
        endcase
    end

    `SOLQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(solq_pkg::QUEUE_DEPTH))
    `SOLQ_ASSERT_ALWAYS(a_write_in_insert, !wr_en || state_reg == solq_pkg::S_DISPATCH || state_reg == solq_pkg::S_INS_SCAN || state_reg == solq_pkg::S_INS_HEAD)
    `SOLQ_ASSERT_NEXT(a_pop_shrinks, state_reg == solq_pkg::S_POP_WAIT, count_reg == $past(count_reg) - CW'(1))
    `SOLQ_ASSERT_NEXT(a_full_drop, state_reg == solq_pkg::S_DISPATCH && op_reg == solq_pkg::OP_INSERT && count_reg == CW'(solq_pkg::QUEUE_DEPTH), $stable(count_reg) && $stable(head_reg))
    `SOLQ_ASSERT_ALWAYS(a_look_in_range, state_reg != solq_pkg::S_LOOK_SCAN || {1'b0, idx_reg} < count_reg)

endmodule

`default_nettype wire
